>>> rtl/nsq_pkg.sv
// shared types and constants of the nine-slice quad generator
`timescale 1ns / 1ps
package nsq_pkg;

    localparam int TERM_W = 42;
    localparam int TEX_W  = 17;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 48;

    localparam logic [IDX_W-1:0] REG_SOURCE_RECT     = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_INSETS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_TEXTURE_SIZE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_PIXELS_PER_UNIT = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPRITE_EXTENT   = 3'd4;

    localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;

    // texture coordinate per grid column (u) and grid row (v)
    typedef struct packed {
        logic [3:0][TEX_W-1:0] u;
        logic [3:0][TEX_W-1:0] v;
    } t_tex_tab;

    // one transform after the products: origin plus half terms,
    // index [axis][0] for the outer extent, [axis][1] for the inner one
    typedef struct packed {
        logic [2:0][31:0]            org;
        logic [2:0][1:0][TERM_W-1:0] rterm;
        logic [2:0][1:0][TERM_W-1:0] uterm;
    } t_terms;

endpackage

>>> rtl/nsq_if.sv
// channel interfaces: transform input, corner output, register writes
`timescale 1ns / 1ps
interface nsq_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    origin_x, origin_y, origin_z, input ready);
    modport sink   (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    origin_x, origin_y, origin_z, output ready);
endinterface

interface nsq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [3:0]         quad_number;
    logic [1:0]         corner_number;
    logic               last_corner;
    modport source (output valid, vertex_x, vertex_y, vertex_z, tex_u, tex_v,
                    quad_number, corner_number, last_corner, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, tex_u, tex_v,
                    quad_number, corner_number, last_corner, output ready);
endinterface

interface nsq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/nsq_setup.sv
// configuration registers and the shared divider for extents and texture coordinates
`timescale 1ns / 1ps
module nsq_setup #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    nsq_cfg_if.sink                               s_cfg,
    output logic                                  o_busy,
    output logic [24+FRACTION_BITS-1:0]           o_w,
    output logic [24+FRACTION_BITS-1:0]           o_h,
    output logic signed [24+FRACTION_BITS:0]      o_iw,
    output logic signed [24+FRACTION_BITS:0]      o_ih,
    output nsq_pkg::t_tex_tab                     o_tex
);
    import nsq_pkg::*;

    localparam int DW  = 24 + FRACTION_BITS;
    localparam int EW  = DW + 1;
    localparam int SHL = (FRACTION_BITS >= 12) ? FRACTION_BITS - 12 : 0;
    localparam int SHR = (FRACTION_BITS < 12) ? 12 - FRACTION_BITS : 0;
    localparam int CW  = $clog2(DW);

    localparam logic [3:0] JOB_IW   = 4'd0;
    localparam logic [3:0] JOB_IH   = 4'd1;
    localparam logic [3:0] JOB_U0   = 4'd2;
    localparam logic [3:0] JOB_V0   = 4'd6;
    localparam logic [3:0] JOB_LAST = 4'd9;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV} t_state;

    t_state             r_state;
    logic [3:0]         r_job;
    logic [CW-1:0]      r_cnt;
    logic [23:0]        r_rem;
    logic [DW-1:0]      r_quo;
    logic [47:0]        r_src;
    logic [47:0]        r_ins;
    logic [25:0]        r_tsz;
    logic [23:0]        r_ppu;
    logic [47:0]        r_ext;
    logic signed [EW-1:0] r_iw;
    logic signed [EW-1:0] r_ih;
    t_tex_tab           r_tex;

    logic               cfg_fire;
    logic signed [13:0] sx, sy, sw, sh, il, it, ir, ib;
    logic signed [13:0] nu [4];
    logic signed [13:0] nv [4];
    logic [12:0]        sum_lr, sum_tb;
    logic [23:0]        ppu_nz;
    logic [12:0]        texw_nz, texh_nz;
    logic [DW-1:0]      dividend;
    logic [23:0]        divisor;
    logic [24:0]        rem_sh;
    logic               ge;
    logic [23:0]        rem_nx;
    logic [DW-1:0]      quo_nx;
    logic [TEX_W-1:0]   tex_q;
    logic [3:0]         u_off, v_off;

    function automatic logic [12:0] clamp13(input logic signed [13:0] n);
        return n[13] ? 13'd0 : n[12:0];
    endfunction

    assign s_cfg.ready = 1'b1;
    assign cfg_fire    = s_cfg.valid;

    assign o_w = (DW'(r_ext[23:0]) << SHL) >> SHR;
    assign o_h = (DW'(r_ext[47:24]) << SHL) >> SHR;

    always_comb begin
        sx = $signed({2'b00, r_src[11:0]});
        sy = $signed({2'b00, r_src[23:12]});
        sw = $signed({2'b00, r_src[35:24]});
        sh = $signed({2'b00, r_src[47:36]});
        il = $signed({2'b00, r_ins[11:0]});
        it = $signed({2'b00, r_ins[23:12]});
        ir = $signed({2'b00, r_ins[35:24]});
        ib = $signed({2'b00, r_ins[47:36]});
        nu[0] = sx;
        nu[1] = sx + il;
        nu[2] = sx + sw - ir;
        nu[3] = sx + sw;
        // rows use the bottom inset first, then the top one
        nv[0] = sy;
        nv[1] = sy + ib;
        nv[2] = sy + sh - it;
        nv[3] = sy + sh;
        sum_lr  = {1'b0, r_ins[11:0]} + {1'b0, r_ins[35:24]};
        sum_tb  = {1'b0, r_ins[23:12]} + {1'b0, r_ins[47:36]};
        ppu_nz  = (r_ppu == 24'd0) ? 24'd1 : r_ppu;
        texw_nz = (r_tsz[12:0] == 13'd0) ? 13'd1 : r_tsz[12:0];
        texh_nz = (r_tsz[25:13] == 13'd0) ? 13'd1 : r_tsz[25:13];
        u_off   = r_job - JOB_U0;
        v_off   = r_job - JOB_V0;
        unique case (r_job)
            JOB_IW: begin
                dividend = {sum_lr, {(11+FRACTION_BITS){1'b0}}};
                divisor  = ppu_nz;
            end
            JOB_IH: begin
                dividend = {sum_tb, {(11+FRACTION_BITS){1'b0}}};
                divisor  = ppu_nz;
            end
            4'd2, 4'd3, 4'd4, 4'd5: begin
                dividend = {{(DW-29){1'b0}}, clamp13(nu[u_off[1:0]]), 16'd0};
                divisor  = {11'd0, texw_nz};
            end
            4'd6, 4'd7, 4'd8, 4'd9: begin
                dividend = {{(DW-29){1'b0}}, clamp13(nv[v_off[1:0]]), 16'd0};
                divisor  = {11'd0, texh_nz};
            end
            default: begin
                dividend = '0;
                divisor  = 24'd1;
            end
        endcase
        rem_sh = {r_rem, r_quo[DW-1]};
        ge     = rem_sh >= {1'b0, divisor};
        rem_nx = ge ? 24'(rem_sh - {1'b0, divisor}) : rem_sh[23:0];
        quo_nx = {r_quo[DW-2:0], ge};
        tex_q  = (quo_nx > DW'(TEX_ONE)) ? TEX_ONE : quo_nx[TEX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_job   <= JOB_IW;
            r_cnt   <= '0;
            r_src   <= '0;
            r_ins   <= '0;
            r_tsz   <= 26'd8193;
            r_ppu   <= 24'd4096;
            r_ext   <= 48'd68719480832;
        end else if (cfg_fire) begin
            unique case (s_cfg.index)
                REG_SOURCE_RECT:     r_src <= s_cfg.data;
                REG_FRAME_INSETS:    r_ins <= s_cfg.data;
                REG_TEXTURE_SIZE:    r_tsz <= s_cfg.data[25:0];
                REG_PIXELS_PER_UNIT: r_ppu <= s_cfg.data[23:0];
                REG_SPRITE_EXTENT:   r_ext <= s_cfg.data;
                default: ;
            endcase
            r_state <= S_LOAD;
            r_job   <= JOB_IW;
        end else begin
            unique case (r_state)
                S_IDLE: ;
                S_LOAD: begin
                    r_quo   <= dividend;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= quo_nx;
                    r_rem <= rem_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DW - 1)) begin
                        if (r_job == JOB_IW) begin
                            r_iw <= $signed({1'b0, o_w}) - $signed({1'b0, quo_nx});
                        end else if (r_job == JOB_IH) begin
                            r_ih <= $signed({1'b0, o_h}) - $signed({1'b0, quo_nx});
                        end else if (r_job < JOB_V0) begin
                            r_tex.u[u_off[1:0]] <= tex_q;
                        end else begin
                            r_tex.v[v_off[1:0]] <= tex_q;
                        end
                        r_job   <= r_job + 1'b1;
                        r_state <= (r_job == JOB_LAST) ? S_IDLE : S_LOAD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_iw   = r_iw;
    assign o_ih   = r_ih;
    assign o_tex  = r_tex;

endmodule

>>> rtl/nsq_front.sv
// front end: takes a transform and forms the twelve half terms on one multiplier
`timescale 1ns / 1ps
module nsq_front #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    nsq_in_if.sink                             s_in,
    input  logic                               i_hold,
    input  logic [24+FRACTION_BITS-1:0]        i_w,
    input  logic [24+FRACTION_BITS-1:0]        i_h,
    input  logic signed [24+FRACTION_BITS:0]   i_iw,
    input  logic signed [24+FRACTION_BITS:0]   i_ih,
    output logic                               o_push_valid,
    input  logic                               i_push_ready,
    output nsq_pkg::t_terms                    o_push_data
);
    import nsq_pkg::*;

    localparam int DW = 24 + FRACTION_BITS;
    localparam int EW = DW + 1;
    localparam int HW = (DW + 1) / 2;
    localparam int PW = 32 + HW;
    localparam int FW = 32 + 2 * HW;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_PUSH} t_state;

    t_state                r_state;
    logic [4:0]            r_step;
    logic signed [31:0]    r_ax [6];
    logic [31:0]           r_org [3];
    logic [PW-1:0]         r_prod;
    logic                  r_pv;
    logic [3:0]            r_pt;
    logic                  r_pph;
    logic                  r_pneg;
    logic [PW-1:0]         r_acc;
    logic [TERM_W-1:0]     r_terms [12];

    logic [3:0]            t;
    logic [2:0]            a;
    logic signed [31:0]    axis;
    logic [31:0]           ax_mag;
    logic signed [EW-1:0]  ext;
    logic [EW-1:0]         ext_neg_v;
    logic [DW-1:0]         ext_mag;
    logic [DW-1:0]         ext_hi;
    logic [HW-1:0]         chunk;
    logic [FW-1:0]         full;
    logic [FW-1:0]         mag;
    logic [40:0]           mag_sat;
    logic [TERM_W-1:0]     mag_s;

    always_comb begin
        t     = r_step[4:1];
        a     = t[3:1];
        axis  = r_ax[a];
        ax_mag = axis[31] ? 32'(-axis) : axis;
        if (a < 3'd3) begin
            ext = t[0] ? i_iw : $signed({1'b0, i_w});
        end else begin
            ext = t[0] ? i_ih : $signed({1'b0, i_h});
        end
        ext_neg_v = -ext;
        ext_mag   = ext[EW-1] ? ext_neg_v[DW-1:0] : ext[DW-1:0];
        ext_hi    = ext_mag >> HW;
        chunk     = r_step[0] ? ext_hi[HW-1:0] : ext_mag[HW-1:0];
        // half term: |axis|*|ext| over 2^(fraction+1), capped at 2^40
        full    = FW'(r_acc) + (FW'(r_prod) << HW);
        mag     = full >> (FRACTION_BITS + 1);
        mag_sat = (mag > (FW'(1) << 40)) ? 41'h100_0000_0000 : mag[40:0];
        mag_s   = {1'b0, mag_sat};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_pv   <= (r_state == S_RUN);
            r_prod <= {{HW{1'b0}}, ax_mag} * {{32{1'b0}}, chunk};
            r_pt   <= t;
            r_pph  <= r_step[0];
            r_pneg <= axis[31] ^ ext[EW-1];
            if (r_pv) begin
                if (!r_pph) begin
                    r_acc <= r_prod;
                end else begin
                    r_terms[r_pt] <= r_pneg ? TERM_W'(-mag_s) : mag_s;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_in.valid && s_in.ready) begin
                        r_ax[0]  <= s_in.right_x;
                        r_ax[1]  <= s_in.right_y;
                        r_ax[2]  <= s_in.right_z;
                        r_ax[3]  <= s_in.up_x;
                        r_ax[4]  <= s_in.up_y;
                        r_ax[5]  <= s_in.up_z;
                        r_org[0] <= s_in.origin_x;
                        r_org[1] <= s_in.origin_y;
                        r_org[2] <= s_in.origin_z;
                        r_step   <= '0;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd23) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_pv && r_pph && r_pt == 4'd11) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_in.ready   = (r_state == S_IDLE) && !i_hold;
    assign o_push_valid = (r_state == S_PUSH);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_push_data.org[i]      = r_org[i];
            o_push_data.rterm[i][0] = r_terms[2*i];
            o_push_data.rterm[i][1] = r_terms[2*i+1];
            o_push_data.uterm[i][0] = r_terms[6+2*i];
            o_push_data.uterm[i][1] = r_terms[6+2*i+1];
        end
    end

endmodule

>>> rtl/nsq_fifo.sv
// two-entry queue of finished term sets between front and back
`timescale 1ns / 1ps
module nsq_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  nsq_pkg::t_terms  i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output nsq_pkg::t_terms  o_pop_data
);
    import nsq_pkg::*;

    t_terms     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= i_push_data;
                r_wp        <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> rtl/nsq_back.sv
// back end: walks the nine quads and emits one corner per transfer
`timescale 1ns / 1ps
module nsq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  nsq_pkg::t_terms    i_data,
    input  nsq_pkg::t_tex_tab  i_tex,
    nsq_out_if.source          m_out
);
    import nsq_pkg::*;

    logic               r_valid;
    logic [1:0]         r_q;
    logic [1:0]         r_c;
    logic [1:0]         r_k;
    logic signed [31:0] r_vx, r_vy, r_vz;
    logic [TEX_W-1:0]   r_u, r_v;
    logic [3:0]         r_quad;
    logic [1:0]         r_corner;
    logic               r_last;

    logic               load;
    logic               last;
    logic [1:0]         gx, gy;
    logic signed [31:0] vtx [3];
    logic signed [43:0] sum;

    function automatic logic signed [43:0] pick(input logic [1:0] g,
                                                input logic [TERM_W-1:0] outer,
                                                input logic [TERM_W-1:0] inner);
        logic signed [43:0] o;
        logic signed [43:0] n;
        o = 44'($signed(outer));
        n = 44'($signed(inner));
        unique case (g)
            2'd0: return o;
            2'd1: return n;
            2'd2: return -n;
            2'd3: return -o;
            default: return o;
        endcase
    endfunction

    always_comb begin
        // corner order within a quad: (c+1,q+1), (c+1,q), (c,q), (c,q+1)
        gx   = r_c + ((r_k == 2'd0 || r_k == 2'd1) ? 2'd1 : 2'd0);
        gy   = r_q + ((r_k == 2'd0 || r_k == 2'd3) ? 2'd1 : 2'd0);
        last = (r_q == 2'd2) && (r_c == 2'd2) && (r_k == 2'd3);
        load = i_valid && (!r_valid || m_out.ready);
        sum  = '0;
        for (int i = 0; i < 3; i++) begin
            sum = 44'($signed(i_data.org[i]))
                + pick(gx, i_data.rterm[i][0], i_data.rterm[i][1])
                + pick(gy, i_data.uterm[i][0], i_data.uterm[i][1]);
            if (sum > 44'sd2147483647) begin
                vtx[i] = 32'h7fff_ffff;
            end else if (sum < -44'sd2147483648) begin
                vtx[i] = 32'h8000_0000;
            end else begin
                vtx[i] = sum[31:0];
            end
        end
    end

    assign o_ready = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_q     <= '0;
            r_c     <= '0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_vx     <= vtx[0];
                r_vy     <= vtx[1];
                r_vz     <= vtx[2];
                r_u      <= i_tex.u[gx];
                r_v      <= i_tex.v[gy];
                r_quad   <= 4'({r_q, 1'b0}) + 4'(r_q) + 4'(r_c);
                r_corner <= r_k;
                r_last   <= last;
                r_k      <= r_k + 1'b1;
                if (r_k == 2'd3) begin
                    if (r_c == 2'd2) begin
                        r_c <= '0;
                        r_q <= (r_q == 2'd2) ? 2'd0 : r_q + 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
            end else if (m_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign m_out.valid         = r_valid;
    assign m_out.vertex_x      = r_vx;
    assign m_out.vertex_y      = r_vy;
    assign m_out.vertex_z      = r_vz;
    assign m_out.tex_u         = r_u;
    assign m_out.tex_v         = r_v;
    assign m_out.quad_number   = r_quad;
    assign m_out.corner_number = r_corner;
    assign m_out.last_corner   = r_last;

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last |-> r_quad == 4'd8 && r_corner == 2'd3)
        else $error("last corner flagged away from the final corner");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q != 2'd3 && r_c != 2'd3)
        else $error("quad walk left the three by three grid");

    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |=> r_valid && r_last && r_q == 2'd0 && r_c == 2'd0 && r_k == 2'd0)
        else $error("term set released before its last corner");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_u <= TEX_ONE && r_v <= TEX_ONE)
        else $error("texture coordinate above one");

endmodule

>>> rtl/nine_slice_quad_generator.sv
// top level of the nine-slice quad generator
`timescale 1ns / 1ps
// Nine-slice sprite mesh generator. Each transfer on i_in is one sprite transform
// (right axis, up axis, origin, signed Q16.16); for it the block sends 36 corner
// transfers on o_out, nine quads of four corners, row-major from the top left, the
// final one flagged by last_corner. The back end produces one corner per cycle
// while o_out is ready; the front end forms its twelve half terms on a single
// 32 x ((FRACTION_BITS+25)/2) multiplier, two partial products per term, and a
// two-entry queue lets it work on the next transform while corners are drained.
// After reset and after every register write a setup pass runs one shared
// bit-serial divider over ten quotients (two inner extents, eight texture
// coordinates); no transform is taken during that pass. Register writes are
// taken in every cycle and belong to quiet periods only.
module nine_slice_quad_generator #(
    parameter int FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nsq_in_if.sink     i_in,
    nsq_out_if.source  o_out,
    nsq_cfg_if.sink    i_cfg
);
    import nsq_pkg::*;

    localparam int DW = 24 + FRACTION_BITS;

    logic                setup_busy;
    logic [DW-1:0]       ext_w;
    logic [DW-1:0]       ext_h;
    logic signed [DW:0]  ext_iw;
    logic signed [DW:0]  ext_ih;
    t_tex_tab            tex_tab;
    logic                push_valid;
    logic                push_ready;
    t_terms              push_data;
    logic                pop_valid;
    logic                pop_ready;
    t_terms              pop_data;
    logic                hold;

    // no transform while the setup pass runs or a register write lands
    assign hold = setup_busy || i_cfg.valid;

    nsq_setup #(.FRACTION_BITS(FRACTION_BITS)) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_cfg   (i_cfg),
        .o_busy  (setup_busy),
        .o_w     (ext_w),
        .o_h     (ext_h),
        .o_iw    (ext_iw),
        .o_ih    (ext_ih),
        .o_tex   (tex_tab)
    );

    // front: captures the transform and builds the signed half terms
    nsq_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_in         (i_in),
        .i_hold       (hold),
        .i_w          (ext_w),
        .i_h          (ext_h),
        .i_iw         (ext_iw),
        .i_ih         (ext_ih),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    nsq_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // back: sums origin and two terms per axis, saturates, registers the corner
    nsq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop_valid),
        .o_ready (pop_ready),
        .i_data  (pop_data),
        .i_tex   (tex_tab),
        .m_out   (o_out)
    );

endmodule

>>> test/tb_nine_slice_quad_generator.sv
// self-checking testbench of the nine-slice quad generator
`timescale 1ns / 1ps
module tb_nine_slice_quad_generator;
    import nsq_pkg::*;

    localparam int FRAC = 16;
    // setup pass after every register write: ten divider quotients
    localparam int SETUP_CYCLES = 10 * (25 + FRAC);
    localparam int CORNERS = 36;

    // one corner as the block should send it
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [3:0]         quad;
        logic [1:0]         corner;
        logic               last;
    } t_corner;

    // one sprite transform: right axis, up axis, origin
    typedef struct packed {
        logic signed [2:0][31:0] rgt;
        logic signed [2:0][31:0] up;
        logic signed [2:0][31:0] org;
    } t_xform;

    logic i_clk;
    logic i_rst_n;

    nsq_in_if  in_ch ();
    nsq_out_if out_ch ();
    nsq_cfg_if cfg_ch ();

    nine_slice_quad_generator #(.FRACTION_BITS(FRAC)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // register shadow kept by the predictor
    logic [47:0] sh_rect, sh_insets, sh_ext;
    logic [25:0] sh_tex;
    logic [23:0] sh_ppu;

    t_corner expected_corners[$];
    int      mismatch_count;
    int      corners_seen;
    int      transforms_sent;
    int      idle_pct_in;
    int      idle_pct_out;
    int      hold_off_cycles;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at corner %0d: %s got %0d expected %0d", corners_seen, what, got,
                 want);
        mismatch_count++;
    endtask

    // axis * extent / 2 in Q16.16, truncated toward zero, magnitude clamped at 2^40
    function automatic longint half_term(input longint axis, input longint ext);
        logic [127:0] prod;
        logic [127:0] mag;
        logic         neg;
        neg  = (axis < 0) != (ext < 0);
        prod = 128'(axis < 0 ? -axis : axis) * 128'(ext < 0 ? -ext : ext);
        mag  = prod >> (FRAC + 1);
        if (mag > (128'd1 << 40)) mag = 128'd1 << 40;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [31:0] clamp32(input longint s);
        if (s > 64'sd2147483647) return 32'h7fffffff;
        if (s < -64'sd2147483648) return 32'h80000000;
        return s[31:0];
    endfunction

    function automatic logic [16:0] tex_coord(input longint num, input longint size);
        longint q;
        if (num <= 0) return '0;
        if (size == 0) size = 1;
        q = (num << 16) / size;
        return q > 65536 ? TEX_ONE : 17'(q);
    endfunction

    // all 36 corners of one transform, in emission order
    task automatic predict_mesh(input t_xform x);
        longint  w, h, iw, ih, ppu, s;
        longint  col[4], row[4];
        logic [16:0] tu[4], tv[4];
        longint  rx, ry, rw, rh, il, it, ir, ib, tw, th;
        int      gx, gy, n;
        int      dc[4], dr[4];
        t_corner c;
        dc = '{1, 1, 0, 0};
        dr = '{1, 0, 0, 1};
        rx = sh_rect[11:0];   ry = sh_rect[23:12];
        rw = sh_rect[35:24];  rh = sh_rect[47:36];
        il = sh_insets[11:0]; it = sh_insets[23:12];
        ir = sh_insets[35:24]; ib = sh_insets[47:36];
        tw = sh_tex[12:0];    th = sh_tex[25:13];
        ppu = sh_ppu == 0 ? 1 : sh_ppu;
        w = longint'(sh_ext[23:0]) << (FRAC - 12);
        h = longint'(sh_ext[47:24]) << (FRAC - 12);
        iw = w - ((il + ir) << (11 + FRAC)) / ppu;
        ih = h - ((it + ib) << (11 + FRAC)) / ppu;
        col = '{w, iw, -iw, -w};
        row = '{h, ih, -ih, -h};
        tu = '{tex_coord(rx, tw), tex_coord(rx + il, tw), tex_coord(rx + rw - ir, tw),
               tex_coord(rx + rw, tw)};
        // row 1 takes the bottom inset, row 2 the top inset
        tv = '{tex_coord(ry, th), tex_coord(ry + ib, th), tex_coord(ry + rh - it, th),
               tex_coord(ry + rh, th)};
        n = 0;
        for (int q = 0; q < 3; q++) begin
            for (int cc = 0; cc < 3; cc++) begin
                for (int k = 0; k < 4; k++) begin
                    gx = cc + dc[k];
                    gy = q + dr[k];
                    s = longint'($signed(x.org[2])) + half_term($signed(x.rgt[2]), col[gx])
                        + half_term($signed(x.up[2]), row[gy]);
                    c.vx = clamp32(s);
                    s = longint'($signed(x.org[1])) + half_term($signed(x.rgt[1]), col[gx])
                        + half_term($signed(x.up[1]), row[gy]);
                    c.vy = clamp32(s);
                    s = longint'($signed(x.org[0])) + half_term($signed(x.rgt[0]), col[gx])
                        + half_term($signed(x.up[0]), row[gy]);
                    c.vz = clamp32(s);
                    c.u = tu[gx];
                    c.v = tv[gy];
                    c.quad = 4'(q * 3 + cc);
                    c.corner = 2'(k);
                    c.last = (n == CORNERS - 1);
                    expected_corners.push_back(c);
                    n++;
                end
            end
        end
    endtask

    // register write during a quiet period, then wait out the setup pass
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [47:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_SOURCE_RECT:     sh_rect = value;
            REG_FRAME_INSETS:    sh_insets = value;
            REG_TEXTURE_SIZE:    sh_tex = value[25:0];
            REG_PIXELS_PER_UNIT: sh_ppu = value[23:0];
            REG_SPRITE_EXTENT:   sh_ext = value;
            default: ;
        endcase
        repeat (SETUP_CYCLES + 20) @(posedge i_clk);
    endtask

    // wait until the block has sent every predicted corner
    task automatic drain;
        while (expected_corners.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_xform(input t_xform x);
        while ($urandom_range(99) < idle_pct_in) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.right_x  <= x.rgt[2];
        in_ch.right_y  <= x.rgt[1];
        in_ch.right_z  <= x.rgt[0];
        in_ch.up_x     <= x.up[2];
        in_ch.up_y     <= x.up[1];
        in_ch.up_z     <= x.up[0];
        in_ch.origin_x <= x.org[2];
        in_ch.origin_y <= x.org[1];
        in_ch.origin_z <= x.org[0];
        do @(posedge i_clk); while (!in_ch.ready);
        predict_mesh(x);
        transforms_sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(131072)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_xform rand_xform();
        t_xform x;
        for (int i = 0; i < 3; i++) begin
            x.rgt[i] = rand_word();
            x.up[i]  = rand_word();
            x.org[i] = rand_word();
        end
        return x;
    endfunction

    // output side: random stalls, one long hold-off on request, and the checks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_corners.size() == 0) begin
                    $display("corner transfer with nothing expected");
                    mismatch_count++;
                end else begin
                    t_corner e;
                    e = expected_corners.pop_front();
                    if (out_ch.vertex_x !== e.vx)
                        report_mismatch("vertex_x", out_ch.vertex_x, e.vx);
                    if (out_ch.vertex_y !== e.vy)
                        report_mismatch("vertex_y", out_ch.vertex_y, e.vy);
                    if (out_ch.vertex_z !== e.vz)
                        report_mismatch("vertex_z", out_ch.vertex_z, e.vz);
                    if (out_ch.tex_u !== e.u) report_mismatch("tex_u", out_ch.tex_u, e.u);
                    if (out_ch.tex_v !== e.v) report_mismatch("tex_v", out_ch.tex_v, e.v);
                    if (out_ch.quad_number !== e.quad)
                        report_mismatch("quad_number", out_ch.quad_number, e.quad);
                    if (out_ch.corner_number !== e.corner)
                        report_mismatch("corner_number", out_ch.corner_number, e.corner);
                    if (out_ch.last_corner !== e.last)
                        report_mismatch("last_corner", out_ch.last_corner, e.last);
                end
                corners_seen++;
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= idle_pct_out);
            end
        end
    end

    // directed stimulus: register setting plus transform, with hand-typed
    // expectations only where they are obvious
    typedef struct {
        logic [47:0] rect, insets, ext;
        logic [25:0] tex;
        logic [23:0] ppu;
        t_xform      x;
    } t_row;

    t_row rows[$];

    function automatic t_xform mk(input logic [31:0] r, input logic [31:0] u,
                                  input logic [31:0] o);
        t_xform x;
        x.rgt = {r, r, r};
        x.up  = {u, u, u};
        x.org = {o, o, o};
        return x;
    endfunction

    initial begin
        t_row   r;
        t_corner c;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.right_x, in_ch.right_y, in_ch.right_z} = '0;
        {in_ch.up_x, in_ch.up_y, in_ch.up_z} = '0;
        {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        mismatch_count = 0;
        corners_seen = 0;
        transforms_sent = 0;
        idle_pct_in = 0;
        idle_pct_out = 0;
        hold_off_cycles = 0;
        sh_rect = '0;
        sh_insets = '0;
        sh_tex = 26'd8193;
        sh_ppu = 24'd4096;
        sh_ext = 48'd68719480832;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // setup pass after reset
        repeat (SETUP_CYCLES + 20) @(posedge i_clk);

        // after reset, zero transform: every corner at the origin, texture all zero
        send_xform(mk(32'd0, 32'd0, 32'd0));
        in_ch.valid <= 1'b0;
        for (int i = 0; i < CORNERS; i++) begin
            c = '{32'sd0, 32'sd0, 32'sd0, 17'd0, 17'd0, 4'(i / 4), 2'(i % 4), i == 35};
            if (expected_corners[i] !== c) report_mismatch("hand-typed corner", i, 0);
        end
        drain();

        // table of settings: extremes, zero ppu and texture size, oversize insets
        r.x = mk(32'h0001_0000, 32'h0001_0000, 32'h0);
        r.rect = {12'd16, 12'd16, 12'd0, 12'd0}; r.insets = {12'd4, 12'd4, 12'd4, 12'd4};
        r.tex = {13'd16, 13'd16}; r.ppu = 24'd4096; r.ext = {24'd4096, 24'd8192};
        rows.push_back(r);
        r.rect = '1; r.insets = '1; r.tex = '1; r.ppu = 24'hffffff; r.ext = '1;
        r.x = mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        rows.push_back(r);
        r.x = mk(32'h80000000, 32'h80000000, 32'h80000000);
        rows.push_back(r);
        // zero ppu and zero texture size, insets wider than the sprite
        r.rect = {12'd100, 12'd50, 12'd7, 12'd3}; r.insets = {12'd90, 12'd80, 12'd70, 12'd60};
        r.tex = '0; r.ppu = '0; r.ext = {24'd1, 24'd1};
        r.x = mk(32'h0002_8000, 32'hfffe_0000, 32'h0010_0000);
        rows.push_back(r);
        r.tex = {13'd1, 13'd0}; r.ppu = 24'd1; r.ext = '0;
        r.x = mk(32'hffff_ffff, 32'h1, 32'h7fff_0000);
        rows.push_back(r);
        // texture coordinate near one half and clamped above one
        r.rect = {12'd0, 12'd10, 12'd4095, 12'd4095}; r.insets = '0;
        r.tex = {13'd20, 13'd8191}; r.ppu = 24'd2048; r.ext = {24'd123456, 24'd654321};
        r.x = mk(32'h1234_5678, 32'hedcb_a987, 32'h0);
        rows.push_back(r);

        foreach (rows[i]) begin
            in_ch.valid <= 1'b0;
            drain();
            write_reg(REG_SOURCE_RECT, rows[i].rect);
            write_reg(REG_FRAME_INSETS, rows[i].insets);
            write_reg(REG_TEXTURE_SIZE, 48'(rows[i].tex));
            write_reg(REG_PIXELS_PER_UNIT, 48'(rows[i].ppu));
            write_reg(REG_SPRITE_EXTENT, rows[i].ext);
            for (int k = 0; k < 3; k++) send_xform(k == 0 ? rows[i].x : rand_xform());
        end
        // out-of-range register index is ignored
        in_ch.valid <= 1'b0;
        drain();
        write_reg(3'd7, '1);
        write_reg(3'd5, '1);
        send_xform(rows[0].x);

        // random part: back-to-back first, then idling on both sides
        for (int ph = 0; ph < 8; ph++) begin
            in_ch.valid <= 1'b0;
            drain();
            idle_pct_in  = ph == 0 ? 0 : 6;
            idle_pct_out = ph == 0 ? 0 : 6;
            if (ph > 0) begin
                write_reg(REG_SOURCE_RECT, 48'({$urandom, $urandom}));
                write_reg(REG_FRAME_INSETS, $urandom_range(1) ? 48'({$urandom, $urandom}) :
                          {12'($urandom_range(40)), 12'($urandom_range(40)),
                           12'($urandom_range(40)), 12'($urandom_range(40))});
                write_reg(REG_TEXTURE_SIZE, 48'($urandom));
                write_reg(REG_PIXELS_PER_UNIT, 48'($urandom_range(8192, 1)));
                write_reg(REG_SPRITE_EXTENT, 48'({$urandom, $urandom}));
            end
            // long stall on the output so the block backs up its input
            if (ph == 3) hold_off_cycles = 400;
            for (int k = 0; k < 20; k++) send_xform(rand_xform());
        end
        in_ch.valid <= 1'b0;
        drain();
        repeat (100) @(posedge i_clk);

        $display("covered %0d transforms and %0d corners over directed and random settings",
                 transforms_sent, corners_seen);
        if (mismatch_count == 0 && expected_corners.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
